// File: rtl/sih_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sih_pkg
// Shared types and constants for the string intern hash table.
// ----------------------------------------------------------------------------
package sih_pkg;

    localparam int TABLE_SIZE  = 256;
    localparam int MAX_KEY_LEN = 64;

    localparam logic [31:0] FNV_BASIS = 32'd2166136261;
    localparam logic [31:0] FNV_PRIME = 32'd16777619;

    localparam logic [1:0] ST_FOUND    = 2'd0;
    localparam logic [1:0] ST_INSERTED = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_TOO_LONG = 2'd3;

    typedef enum logic [2:0] {
        S_GATHER,
        S_PROBE,
        S_CMP,
        S_WRITE,
        S_RESULT
    } ctrl_state_t;

    // controller -> datapath
    typedef struct packed {
        logic fold;       // take the input item
        logic start;      // latch key, begin probing
        logic step_slot;  // advance probe index
        logic cmp_start;  // restart byte compare
        logic cmp_step;   // advance byte compare
        logic insert;     // write the new slot
        logic load_out;   // capture result
        logic [1:0] res_status;
        logic zero_slot;
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic too_long;
        logic slot_free;
        logic slot_hdr_match;
        logic cmp_done;
        logic cmp_mismatch;
        logic probes_done;
        logic limit_hit;
        logic in_last;
        logic hdr_pend;   // slot header read still in flight
    } dp_stat_t;

endpackage
`default_nettype wire

// File: rtl/sih_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sih_in_if / sih_out_if
// Valid/ready channels carrying key bytes in and lookup results out.
// ----------------------------------------------------------------------------
interface sih_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] key_byte;
    logic       is_last;
    logic       is_empty;
    modport source (output valid, key_byte, is_last, is_empty, input ready);
    modport sink   (input valid, key_byte, is_last, is_empty, output ready);
endinterface

interface sih_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  slot_index;
    logic [1:0]  status;
    logic [31:0] key_hash;
    modport source (output valid, slot_index, status, key_hash, input ready);
    modport sink   (input valid, slot_index, status, key_hash, output ready);
endinterface
`default_nettype wire

// File: rtl/sih_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sih_ctrl
// Sequencer: gathers bytes, walks probes, compares stored strings, answers.
// ----------------------------------------------------------------------------
module sih_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire logic            out_busy,
    input  sih_pkg::dp_stat_t    stat,
    output sih_pkg::dp_cmd_t     cmd
);

    sih_pkg::ctrl_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= sih_pkg::S_GATHER;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sih_pkg::S_GATHER:
            begin
                if (in_valid && in_ready && stat.in_last)
                    state_next = sih_pkg::S_PROBE;
            end
            sih_pkg::S_PROBE:
            begin
                priority if (stat.too_long || stat.probes_done || stat.slot_free)
                    state_next = (stat.slot_free && !stat.too_long && !stat.limit_hit)
                                 ? sih_pkg::S_WRITE : sih_pkg::S_RESULT;
                else if (stat.slot_hdr_match)
                    state_next = sih_pkg::S_CMP;
            end
            sih_pkg::S_CMP:
            begin
                priority if (stat.cmp_mismatch)
                    state_next = sih_pkg::S_PROBE;
                else if (stat.cmp_done)
                    state_next = sih_pkg::S_RESULT;
            end
            sih_pkg::S_WRITE:
            begin
                if (stat.cmp_done)
                    state_next = sih_pkg::S_RESULT;
            end
            sih_pkg::S_RESULT:
                state_next = sih_pkg::S_GATHER;
            default:
                state_next = sih_pkg::S_GATHER;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            sih_pkg::S_GATHER:
            begin
                in_ready = !out_busy;
                cmd.fold = in_valid && in_ready;
                cmd.start = cmd.fold && stat.in_last;
            end
            sih_pkg::S_PROBE:
            begin
                cmd.cmp_start = 1'b1;
                // hold the index until its header has landed
                if (!stat.hdr_pend
                    && !(stat.too_long || stat.probes_done || stat.slot_free)
                    && !stat.slot_hdr_match)
                    cmd.step_slot = 1'b1;
                if (stat.too_long)
                begin
                    cmd.load_out = 1'b1;
                    cmd.res_status = sih_pkg::ST_TOO_LONG;
                    cmd.zero_slot = 1'b1;
                end
                else if (stat.probes_done || (stat.slot_free && stat.limit_hit))
                begin
                    cmd.load_out = 1'b1;
                    cmd.res_status = sih_pkg::ST_FULL;
                    cmd.zero_slot = 1'b1;
                end
            end
            sih_pkg::S_CMP:
            begin
                cmd.cmp_step = 1'b1;
                if (stat.cmp_mismatch)
                    cmd.step_slot = 1'b1;
                else if (stat.cmp_done)
                begin
                    cmd.load_out = 1'b1;
                    cmd.res_status = sih_pkg::ST_FOUND;
                end
            end
            sih_pkg::S_WRITE:
            begin
                cmd.insert = 1'b1;
                cmd.cmp_step = 1'b1;
                if (stat.cmp_done)
                begin
                    cmd.load_out = 1'b1;
                    cmd.res_status = sih_pkg::ST_INSERTED;
                end
            end
            sih_pkg::S_RESULT:
            begin
            end
            default:
            begin
            end
        endcase
    end

    ap_ready_only_gather: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> state_reg == sih_pkg::S_GATHER)
        else $error("input taken outside gather");
    ap_last_probes: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |=> state_reg == sih_pkg::S_PROBE)
        else $error("last byte did not start probe");
    ap_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |=> state_reg == sih_pkg::S_RESULT || state_reg == sih_pkg::S_GATHER)
        else $error("result load out of sequence");

endmodule
`default_nettype wire

// File: rtl/sih_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sih_datapath
// Hash fold, key buffer, slot tables, string store and result register.
// ----------------------------------------------------------------------------
module sih_datapath (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic [7:0]    key_byte,
    input  wire logic          is_last,
    input  wire logic          is_empty,
    input  wire logic          cfg_we,
    input  wire logic [8:0]    cfg_data,
    input  sih_pkg::dp_cmd_t   cmd,
    output sih_pkg::dp_stat_t  stat,
    input  wire logic          out_ready,
    output logic               out_valid,
    output logic [7:0]         slot_index,
    output logic [1:0]         status,
    output logic [31:0]        key_hash
);

    localparam int TABLE_SIZE  = sih_pkg::TABLE_SIZE;
    localparam int MAX_KEY_LEN = sih_pkg::MAX_KEY_LEN;
    localparam int SW = $clog2(TABLE_SIZE);
    localparam int KW = $clog2(MAX_KEY_LEN);
    localparam int LW = $clog2(MAX_KEY_LEN + 2);
    localparam int CW = SW + 1;

    logic [31:0]   hash_reg, key_hash_reg;
    logic [LW-1:0] len_reg, key_len_reg;
    logic [8:0]    fill_reg;
    logic [CW-1:0] count_reg, probes_reg;
    logic [SW-1:0] idx_reg;
    logic [LW-1:0] cmp_reg;
    logic [TABLE_SIZE-1:0] valid_reg;
    logic          hdr_pend_reg, byte_pend_reg;

    logic [7:0]    key_buf [MAX_KEY_LEN];
    logic [31:0]   slot_hash_mem [TABLE_SIZE];
    logic [LW-1:0] slot_len_mem [TABLE_SIZE];
    logic [7:0]    store_mem [TABLE_SIZE*MAX_KEY_LEN];
    logic [31:0]   rd_hash_reg;
    logic [LW-1:0] rd_len_reg;
    logic [7:0]    rd_store_reg, rd_key_reg;

    logic [31:0]   folded;
    logic [63:0]   prod;
    logic [SW+KW-1:0] st_addr;
    logic [KW-1:0] cmp_idx;
    logic [8:0]    limit;
    logic          out_valid_reg;
    logic [7:0]    out_slot_reg;
    logic [1:0]    out_status_reg;

    assign prod   = {32'd0, hash_reg ^ {24'd0, key_byte}} * {32'd0, sih_pkg::FNV_PRIME};
    assign folded = prod[31:0];
    assign cmp_idx = cmp_reg[KW-1:0];
    assign st_addr = {idx_reg, cmp_idx};
    assign limit  = (fill_reg > 9'(TABLE_SIZE)) ? 9'(TABLE_SIZE) : fill_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg      <= sih_pkg::FNV_BASIS;
            len_reg       <= '0;
            fill_reg      <= 9'((TABLE_SIZE * 3) / 4);
            count_reg     <= '0;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
            probes_reg    <= '0;
            cmp_reg       <= '0;
            hdr_pend_reg  <= 1'b0;
            byte_pend_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                fill_reg <= cfg_data;
            if (cmd.start)
            begin
                hash_reg   <= sih_pkg::FNV_BASIS;
                len_reg    <= '0;
                probes_reg <= '0;
            end
            else if (cmd.fold && !is_empty)
            begin
                hash_reg <= folded;
                if (len_reg <= LW'(MAX_KEY_LEN))
                    len_reg <= len_reg + 1'b1;
            end
            // header read lands in the cycle after an index change
            hdr_pend_reg <= cmd.start || cmd.step_slot;
            if (cmd.step_slot)
                probes_reg <= probes_reg + 1'b1;
            if (cmd.cmp_start)
            begin
                cmp_reg <= '0;
                byte_pend_reg <= 1'b1;
            end
            else if (cmd.cmp_step)
            begin
                if (byte_pend_reg)
                    byte_pend_reg <= 1'b0;
                else
                begin
                    cmp_reg <= cmp_reg + 1'b1;
                    byte_pend_reg <= 1'b1;
                end
            end
            if (cmd.insert && stat.cmp_done)
            begin
                valid_reg[idx_reg] <= 1'b1;
                count_reg <= count_reg + 1'b1;
            end
            if (cmd.load_out)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.fold && !is_empty && len_reg < LW'(MAX_KEY_LEN))
            key_buf[len_reg[KW-1:0]] <= key_byte;
        if (cmd.start)
        begin
            key_hash_reg <= is_empty ? hash_reg : folded;
            key_len_reg  <= (!is_empty && len_reg <= LW'(MAX_KEY_LEN))
                            ? len_reg + 1'b1 : len_reg;
            idx_reg      <= is_empty ? hash_reg[SW-1:0] : folded[SW-1:0];
        end
        else if (cmd.step_slot)
            idx_reg <= idx_reg + 1'b1;
        rd_hash_reg  <= slot_hash_mem[idx_reg];
        rd_len_reg   <= slot_len_mem[idx_reg];
        rd_store_reg <= store_mem[st_addr];
        rd_key_reg   <= key_buf[cmp_idx];
        // copy once the key byte for this position has landed
        if (cmd.insert && !byte_pend_reg && cmp_reg < key_len_reg)
            store_mem[st_addr] <= rd_key_reg;
        if (cmd.insert && stat.cmp_done)
        begin
            slot_hash_mem[idx_reg] <= key_hash_reg;
            slot_len_mem[idx_reg]  <= key_len_reg;
        end
        if (cmd.load_out)
        begin
            out_slot_reg   <= cmd.zero_slot ? 8'd0 : 8'(idx_reg);
            out_status_reg <= cmd.res_status;
        end
    end

    always_comb
    begin
        stat = '0;
        stat.in_last     = is_last;
        stat.hdr_pend    = hdr_pend_reg;
        stat.too_long    = key_len_reg > LW'(MAX_KEY_LEN);
        stat.probes_done = probes_reg == CW'(TABLE_SIZE);
        stat.slot_free   = !hdr_pend_reg && !valid_reg[idx_reg];
        stat.limit_hit   = limit <= count_reg;
        stat.slot_hdr_match = !hdr_pend_reg && valid_reg[idx_reg]
                              && rd_hash_reg == key_hash_reg && rd_len_reg == key_len_reg;
        stat.cmp_done     = !byte_pend_reg && cmp_reg >= key_len_reg;
        stat.cmp_mismatch = !byte_pend_reg && cmp_reg < key_len_reg
                            && rd_store_reg != rd_key_reg;
        if (!hdr_pend_reg && stat.probes_done)
            stat.slot_free = 1'b0;
    end

    assign out_valid  = out_valid_reg;
    assign slot_index = out_slot_reg;
    assign status     = out_status_reg;
    assign key_hash   = key_hash_reg;

    ap_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(TABLE_SIZE))
        else $error("entry count overflow");
    ap_insert_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.insert && stat.cmp_done) |-> !valid_reg[idx_reg])
        else $error("insert into occupied slot");
    ap_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid && $stable(key_hash))
        else $error("result dropped while stalled");

endmodule
`default_nettype wire

// File: rtl/string_intern_hash_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// string_intern_hash_table
// Interns byte-serial key strings in an FNV-1a linearly probed table.
// ----------------------------------------------------------------------------
// channel   dir  fields
// key_in    in   key_byte[7:0], is_last, is_empty
// result    out  slot_index[7:0], status[1:0], key_hash[31:0]
// cfg       in   cfg_we, cfg_data[8:0] (fill_limit)
//
// Non-last bytes are folded into the hash as they arrive. A last byte walks
// the table slot by slot; a header hit adds a byte-by-byte compare of the
// stored string, an insert a byte-by-byte write of the key; then the result.
// An overlong key skips the walk and answers from the first probe state.
// Reset clears all valid marks at once; no clearing pass.
// A result waiting on the output register stalls the next key byte.
// ----------------------------------------------------------------------------
module string_intern_hash_table (
    input  wire logic       clk,
    input  wire logic       rst_n,
    sih_in_if.sink          key_in,
    sih_out_if.source       result,
    input  wire logic       cfg_we,
    input  wire logic [8:0] cfg_data
);

    sih_pkg::dp_cmd_t  cmd;
    sih_pkg::dp_stat_t stat;
    logic              out_valid;

    sih_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (key_in.valid),
        .in_ready (key_in.ready),
        .out_busy (out_valid),
        .stat     (stat),
        .cmd      (cmd)
    );

    sih_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .key_byte   (key_in.key_byte),
        .is_last    (key_in.is_last),
        .is_empty   (key_in.is_empty),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data),
        .cmd        (cmd),
        .stat       (stat),
        .out_ready  (result.ready),
        .out_valid  (out_valid),
        .slot_index (result.slot_index),
        .status     (result.status),
        .key_hash   (result.key_hash)
    );

    assign result.valid = out_valid;

endmodule
`default_nettype wire
